// File: rtl/lru_keyed_result_cache_core_macros.svh
// Assertion macros shared by the keyed result cache RTL.
`ifndef LRU_KEYED_RESULT_CACHE_CORE_MACROS_SVH
`define LRU_KEYED_RESULT_CACHE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRUKC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in keyed result cache");

// Next-cycle implication, checked outside reset.
`define LRUKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in keyed result cache");

`endif

// File: rtl/lrukc_pkg.sv
// Package with the shared types and operation codes of the keyed result cache.
package lrukc_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        logic [63:0] hash;
        logic [31:0] length;
    } t_key;

    typedef struct packed {
        logic live;
        logic shift;
    } t_cell_ctrl;

endpackage

// File: rtl/lrukc_cell.sv
// One slot of the recency-ordered entry chain: key and value storage plus match logic.
module lrukc_cell #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  lrukc_pkg::t_key       i_query,
    input  lrukc_pkg::t_cell_ctrl i_ctrl,
    input  logic                  i_hit_in,
    input  logic [VALUE_BITS-1:0] i_hit_val_in,
    output logic                  o_hit_out,
    output logic [VALUE_BITS-1:0] o_hit_val_out,
    input  lrukc_pkg::t_key       i_prev_key,
    input  logic [VALUE_BITS-1:0] i_prev_val,
    output lrukc_pkg::t_key       o_key,
    output logic [VALUE_BITS-1:0] o_val
);
    import lrukc_pkg::*;

    t_key                  r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  match;

    // The frontmost match wins, so a hit from an earlier slot passes straight through.
    assign match         = i_ctrl.live && (r_key == i_query);
    assign o_hit_out     = i_hit_in | match;
    assign o_hit_val_out = (!i_hit_in && match) ? r_val : i_hit_val_in;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key <= i_prev_key;
            r_val <= i_prev_val;
        end
    end

    assign o_key = r_key;
    assign o_val = r_val;

endmodule

// File: rtl/lru_keyed_result_cache_core.sv
// Top level of the keyed result cache: a move-to-front chain of entry slots.
// A result is registered and offered in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while results are taken; the ripple match chain
// through CACHE_ENTRIES slots and the shift it drives set the cycle time.
// Reset (synchronous, active low) empties the cache and the output register; the slot
// contents are not reset and are only read below the live entry count.
module lru_keyed_result_cache_core #(
    parameter int CACHE_ENTRIES = 4,
    parameter int VALUE_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_op,
    input  logic [63:0]           i_key_hash,
    input  logic [31:0]           i_key_length,
    input  logic [VALUE_BITS-1:0] i_value_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_hit,
    output logic [VALUE_BITS-1:0] o_value_out
);
    import lrukc_pkg::*;

    `include "lru_keyed_result_cache_core_macros.svh"

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    // Slot 0 is the most recently used entry; each slot hands its contents to the
    // next one back whenever it is told to shift.
    t_key                  query;
    t_key                  front_key;
    logic [VALUE_BITS-1:0] front_val;
    logic                  accept;
    logic                  is_lookup;
    logic                  is_insert;
    logic                  is_clear;
    logic                  final_hit;
    logic [VALUE_BITS-1:0] final_val;

    logic                  hit_chain [CACHE_ENTRIES+1];
    logic [VALUE_BITS-1:0] val_chain [CACHE_ENTRIES+1];
    t_key                  cell_key  [CACHE_ENTRIES];
    logic [VALUE_BITS-1:0] cell_val  [CACHE_ENTRIES];
    t_cell_ctrl            cell_ctrl [CACHE_ENTRIES];

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_hit;
    logic                  n_hit;
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;

    // The output register frees up either when it is empty or when its result is taken
    // in this same cycle, so transactions can stream at one per cycle while results are taken.
    assign o_ready   = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign is_lookup = (i_op == OP_LOOKUP);
    assign is_insert = (i_op == OP_INSERT);
    assign is_clear  = (i_op == OP_CLEAR);

    assign query.hash   = i_key_hash;
    assign query.length = i_key_length;

    assign hit_chain[0] = 1'b0;
    assign val_chain[0] = '0;
    assign final_hit    = hit_chain[CACHE_ENTRIES];
    assign final_val    = val_chain[CACHE_ENTRIES];

    // The front slot receives the presented key whenever it shifts: on an insert together with the
    // new value, on a lookup hit together with the value found, which moves that entry
    // to the front. Its key is identical to the query, so no key needs to be carried.
    assign front_key = query;
    assign front_val = is_insert ? i_value_in : final_val;

    for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
        // A slot shifts on every insert, and on a lookup hit when the frontmost match
        // lies at or behind it; slots behind the matching entry keep their contents.
        assign cell_ctrl[k].live  = (CNT_W'(k) < r_count);
        assign cell_ctrl[k].shift = accept &&
                                    (is_insert || (is_lookup && final_hit && !hit_chain[k]));

        if (k == 0) begin : g_front
            lrukc_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_query       (query),
                .i_ctrl        (cell_ctrl[k]),
                .i_hit_in      (hit_chain[k]),
                .i_hit_val_in  (val_chain[k]),
                .o_hit_out     (hit_chain[k+1]),
                .o_hit_val_out (val_chain[k+1]),
                .i_prev_key    (front_key),
                .i_prev_val    (front_val),
                .o_key         (cell_key[k]),
                .o_val         (cell_val[k])
            );
        end else begin : g_back
            lrukc_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_query       (query),
                .i_ctrl        (cell_ctrl[k]),
                .i_hit_in      (hit_chain[k]),
                .i_hit_val_in  (val_chain[k]),
                .o_hit_out     (hit_chain[k+1]),
                .o_hit_val_out (val_chain[k+1]),
                .i_prev_key    (cell_key[k-1]),
                .i_prev_val    (cell_val[k-1]),
                .o_key         (cell_key[k]),
                .o_val         (cell_val[k])
            );
        end
    end

    // Entry count: a clear empties the list, an insert grows it until the cache is full,
    // after which the entry in the last slot simply falls off the end of the chain.
    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (is_clear) begin
                n_count = '0;
            end else if (is_insert && (r_count < CNT_W'(CACHE_ENTRIES))) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // Every accepted transaction produces exactly one result; only a lookup can hit.
    always_comb begin
        n_out_valid = r_out_valid;
        n_hit       = r_hit;
        n_value     = r_value;
        if (accept) begin
            n_out_valid = 1'b1;
            n_hit       = is_lookup && final_hit;
            n_value     = (is_lookup && final_hit) ? final_val : '0;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_value <= n_value;
    end

    assign o_valid     = r_out_valid;
    assign o_hit       = r_hit;
    assign o_value_out = r_value;

    `LRUKC_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CACHE_ENTRIES))
    `LRUKC_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, accept && is_clear, r_count == '0)
    `LRUKC_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, accept && is_insert && (r_count < CNT_W'(CACHE_ENTRIES)), r_count == $past(r_count) + CNT_W'(1))
    `LRUKC_ASSERT_NEXT(a_hit_at_front, i_clk, i_rst_n, accept && is_lookup && final_hit, r_hit && (cell_val[0] == r_value) && (cell_key[0] == $past(query)))

endmodule

// File: tb/lru_keyed_result_cache_checker.sv
// Scoreboard for the keyed result cache: predicts every transaction and checks each result.
module lru_keyed_result_cache_checker
    import lrukc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 4,
    parameter int VALUE_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [1:0]            i_op,
    input  logic [63:0]           i_key_hash,
    input  logic [31:0]           i_key_length,
    input  logic [VALUE_BITS-1:0] i_value_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_hit,
    input  logic [VALUE_BITS-1:0] i_value_out,
    output int                    o_mismatch_count,
    output int                    o_pending_count
);

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
    } t_cache_result;

    // Shadow copy of the recency list, slot 0 being the most recently used.
    logic [63:0]           slot_hash   [CACHE_ENTRIES];
    logic [31:0]           slot_length [CACHE_ENTRIES];
    logic [VALUE_BITS-1:0] slot_value  [CACHE_ENTRIES];
    int                    live_entries = 0;
    t_cache_result         awaited_results [$];
    int                    mismatches = 0;

    // Moves slots 0 to last-1 one place towards the back, freeing slot 0.
    task automatic push_back_slots(input int last);
        for (int k = last; k > 0; k--) begin
            slot_hash[k]   = slot_hash[k-1];
            slot_length[k] = slot_length[k-1];
            slot_value[k]  = slot_value[k-1];
        end
    endtask

    task automatic apply_transaction(
        input  logic [1:0]            op,
        input  logic [63:0]           hash,
        input  logic [31:0]           length,
        input  logic [VALUE_BITS-1:0] value,
        output t_cache_result         outcome
    );
        int                    found;
        int                    last;
        logic [VALUE_BITS-1:0] moved_value;
        outcome = '0;
        found   = -1;
        case (op)
            OP_LOOKUP: begin
                for (int i = 0; i < live_entries; i++) begin
                    if (found < 0 && slot_hash[i] == hash && slot_length[i] == length) begin
                        found = i;
                    end
                end
                // A hit moves the frontmost matching entry to the front; a miss
                // leaves the order untouched.
                if (found >= 0) begin
                    moved_value = slot_value[found];
                    push_back_slots(found);
                    slot_hash[0]   = hash;
                    slot_length[0] = length;
                    slot_value[0]  = moved_value;
                    outcome.hit    = 1'b1;
                    outcome.value  = moved_value;
                end
            end
            OP_INSERT: begin
                // A full cache loses whatever sits in the last slot.
                last = (live_entries >= CACHE_ENTRIES) ? CACHE_ENTRIES - 1 : live_entries;
                if (live_entries < CACHE_ENTRIES) begin
                    live_entries++;
                end
                push_back_slots(last);
                slot_hash[0]   = hash;
                slot_length[0] = length;
                slot_value[0]  = value;
            end
            OP_CLEAR: begin
                live_entries = 0;
            end
            default: begin
                // The unused code changes nothing and reports a miss.
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_cache_result predicted;
        t_cache_result outcome;
        if (!i_rst_n) begin
            live_entries = 0;
            awaited_results.delete();
        end else begin
            // The result leaving now always belongs to an earlier transaction,
            // so it is checked before this edge's input is predicted.
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected result hit=%0d value=%h",
                                 $realtime, i_hit, i_value_out);
                    end
                    mismatches++;
                end else begin
                    predicted = awaited_results.pop_front();
                    if (i_hit !== predicted.hit || i_value_out !== predicted.value) begin
                        if (mismatches < 10) begin
                            $display("%0t: result mismatch: expected hit=%0d value=%h, got hit=%0d value=%h",
                                     $realtime, predicted.hit, predicted.value, i_hit, i_value_out);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_transaction(i_op, i_key_hash, i_key_length, i_value_in, outcome);
                awaited_results.push_back(outcome);
            end
        end
        o_mismatch_count = mismatches;
        o_pending_count  = awaited_results.size();
    end

endmodule

// File: tb/lru_keyed_result_cache_core_tb.sv
// Testbench top for the keyed result cache: stimulus, back-pressure, watchdog and verdict.
module lru_keyed_result_cache_core_tb;
    import lrukc_pkg::*;

    localparam int         CACHE_ENTRIES = 4;
    localparam int         VALUE_BITS    = 16;
    localparam int         RANDOM_ITEMS  = 1530;
    // The last stretch of the random part runs with no idling on either side.
    localparam int         CALM_TAIL     = 200;
    localparam int         KEY_POOL_SIZE = 6;
    // Longest correct silence is a sender gap plus a receiver stall.
    localparam int         STALL_LIMIT   = 2000;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_op = OP_LOOKUP;
    logic [63:0]           i_key_hash = '0;
    logic [31:0]           i_key_length = '0;
    logic [VALUE_BITS-1:0] i_value_in = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_hit;
    logic [VALUE_BITS-1:0] o_value_out;

    int mismatch_count;
    int pending_count;
    int silent_cycles = 0;
    int ready_stall_left = 0;
    bit allow_idling = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lru_keyed_result_cache_core #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .VALUE_BITS    (VALUE_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_key_hash   (i_key_hash),
        .i_key_length (i_key_length),
        .i_value_in   (i_value_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit        (o_hit),
        .o_value_out  (o_value_out)
    );

    lru_keyed_result_cache_checker #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .VALUE_BITS    (VALUE_BITS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_op             (i_op),
        .i_key_hash       (i_key_hash),
        .i_key_length     (i_key_length),
        .i_value_in       (i_value_in),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_hit            (o_hit),
        .i_value_out      (o_value_out),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // Result back-pressure: the receiver stalls in random bursts while
    // idling is allowed, and otherwise takes every result at once.
    always @(negedge i_clk) begin
        if (ready_stall_left != 0) begin
            ready_stall_left <= ready_stall_left - 1;
            i_ready          <= 1'b0;
        end else if (allow_idling && $urandom_range(0, 7) == 0) begin
            ready_stall_left <= $urandom_range(0, 16);
            i_ready          <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // The watchdog counts cycles in which neither channel completes a transaction.
    // A hung block trips it long before the run could finish normally.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            silent_cycles <= 0;
        end else if (silent_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            silent_cycles <= silent_cycles + 1;
        end
    end

    function automatic t_key random_key();
        t_key key;
        key.hash   = {$urandom, $urandom};
        key.length = $urandom;
        return key;
    endfunction

    // Offers one transaction, possibly after a short idle gap, and returns at the
    // falling edge after it has been accepted. Valid stays high with the payload
    // held until then, and is only dropped when a gap actually follows.
    task automatic send_transaction(
        input logic [1:0]            op,
        input t_key                  key,
        input logic [VALUE_BITS-1:0] value
    );
        int gap;
        gap = 0;
        if (allow_idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_key_hash   <= key.hash;
        i_key_length <= key.length;
        i_value_in   <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_key                  zero_key;
        t_key                  ones_key;
        t_key                  mixed_key;
        t_key                  dup_key;
        t_key                  late_key;
        t_key                  stripe_key;
        t_key                  key;
        t_key                  key_pool [KEY_POOL_SIZE];
        logic [1:0]            op;
        logic [VALUE_BITS-1:0] value;
        int                    roll;
        int                    pick;

        zero_key   = {64'h0, 32'h0};
        ones_key   = {64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF};
        mixed_key  = {64'hFFFF_FFFF_FFFF_FFFF, 32'h0};
        dup_key    = {64'h0123_4567_89AB_CDEF, 32'd5};
        late_key   = {64'hFEDC_BA98_7654_3210, 32'd7};
        stripe_key = {64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555};
        for (int i = 0; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = random_key();
        end

        // Synchronous reset, asserted at the start and never asserted again.
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. It starts with a clear and a lookup on the empty cache,
        // then exercises the all-zero and all-one keys, keys that match on only
        // one of the two fields, a duplicate insert, eviction from a full cache,
        // promotion of the oldest entry and the unused operation code.
        send_transaction(OP_CLEAR, zero_key, '0);
        send_transaction(OP_LOOKUP, zero_key, '0);
        send_transaction(OP_INSERT, zero_key, '0);
        send_transaction(OP_LOOKUP, zero_key, '1);
        send_transaction(OP_INSERT, ones_key, '1);
        send_transaction(OP_LOOKUP, ones_key, '0);
        send_transaction(OP_LOOKUP, mixed_key, '0);
        send_transaction(OP_LOOKUP, {64'h0, 32'hFFFF_FFFF}, '0);
        send_transaction(OP_INSERT, dup_key, 16'h0001);
        send_transaction(OP_INSERT, dup_key, 16'h0002);
        send_transaction(OP_LOOKUP, dup_key, '0);
        // The cache is full now, so this insert pushes the all-zero key out.
        send_transaction(OP_INSERT, late_key, 16'h0003);
        send_transaction(OP_LOOKUP, zero_key, '0);
        send_transaction(OP_LOOKUP, ones_key, '0);
        send_transaction(OP_LOOKUP, dup_key, '0);
        send_transaction(OP_UNUSED, late_key, 16'hBEEF);
        send_transaction(OP_LOOKUP, late_key, '0);
        send_transaction(OP_CLEAR, ones_key, '1);
        send_transaction(OP_LOOKUP, late_key, '0);
        send_transaction(OP_INSERT, stripe_key, 16'h5555);
        send_transaction(OP_LOOKUP, stripe_key, '0);
        send_transaction(OP_INSERT, ~stripe_key, 16'hAAAA);
        send_transaction(OP_LOOKUP, ~stripe_key, '0);

        // Random part. Keys come mostly from a small pool a little larger than
        // the cache, so that hits, misses, duplicates and evictions are all
        // common. Some lookups use fresh keys or keys one bit away from a pool
        // key, and the pool itself drifts slowly.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            allow_idling = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 150) % 3 != 2);
            if ($urandom_range(0, 49) == 0) begin
                key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] = random_key();
            end
            roll  = $urandom_range(0, 99);
            key   = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            value = VALUE_BITS'($urandom);
            if (roll < 3) begin
                op  = OP_CLEAR;
                key = random_key();
            end else if (roll < 6) begin
                op  = OP_UNUSED;
                key = random_key();
            end else if (roll < 40) begin
                op = OP_INSERT;
                if ($urandom_range(0, 9) == 0) begin
                    key = random_key();
                end
            end else begin
                op   = OP_LOOKUP;
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    key = random_key();
                end else if (pick == 1) begin
                    key.length ^= 32'd1 << $urandom_range(0, 31);
                end else if (pick == 2) begin
                    key.hash ^= 64'd1 << $urandom_range(0, 63);
                end
            end
            send_transaction(op, key, value);
        end

        // Drain: wait for every expected result, then keep watching the output
        // so that any stray result would still be seen.
        i_valid      <= 1'b0;
        allow_idling = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/lrukc_pkg.sv
rtl/lrukc_cell.sv
rtl/lru_keyed_result_cache_core.sv
tb/lru_keyed_result_cache_checker.sv
tb/lru_keyed_result_cache_core_tb.sv
